// ===== rtl/c8x_pkg.sv =====
// Package for the CHIP-8 instruction executor: sizes, function codes, controller
// states, word types and the command/status structs between controller and datapath.
// No dependencies.
package c8x_pkg;

  localparam int StackDepth = 16;
  localparam int SpW        = $clog2(StackDepth);
  localparam int MemBytes   = 4096;
  localparam int MemAw      = 12;
  localparam int KeyCount   = 16;
  localparam int FontHeight = 5;

  typedef enum logic [1:0] {
    FUNC_EXEC  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EXEC  = 9'b000000010,
    ST_RDWT  = 9'b000000100,
    ST_RET   = 9'b000001000,
    ST_BCD   = 9'b000010000,
    ST_SAVE  = 9'b000100000,
    ST_LOAD  = 9'b001000000,
    ST_LDWT  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  // source of the memory write byte
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_BCD  = 2'd1,
    SRC_REG  = 2'd2
  } mem_src_e;

  // input and output words
  typedef struct packed {
    func_e       func;
    logic [15:0] opcode;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
  } in_word_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [7:0]  read_data;
    logic        clear_screen;
    logic        unknown_opcode;
    logic        waiting_key;
    logic        sound_active;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;    // latch the accepted input word
    logic       exec;       // execute the simple part of the opcode
    logic       rd_data;    // latch memory byte as read_data
    logic       ret_pc;     // load pc from stack read data
    logic       mem_we;     // memory write strobe
    mem_src_e   mem_src;    // input data, bcd digit or register
    logic       ld_reg;     // load V[cnt] from memory read data
    logic [3:0] cnt;        // step count for bcd / save / load
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       is_ret;
    logic       is_bcd;
    logic       is_save;
    logic       is_load;
    logic [3:0] x;
  } sts_t;

endpackage

// ===== rtl/c8x_stream_if.sv =====
// Valid/ready stream interface, parameterized by payload type.
// Depends on nothing.
interface c8x_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/chip8_instruction_executor_unit.sv =====
// CHIP-8 instruction executor, top level.
// Channels: in_i (sink) carries func, opcode, mem_address, mem_data,
//   key_state and random_byte; out_o (source) carries next_pc, read_data,
//   clear_screen, unknown_opcode, waiting_key and sound_active.
// One word in gives one word out. The block takes one word at a time:
//   in_i.ready is high only when no word is in flight.
// After accept the word is executed in ST_EXEC; a memory read, 00EE, Fx33,
//   Fx55 and Fx65 then pass through ST_RDWT, ST_RET, ST_BCD, ST_SAVE or
//   ST_LOAD/ST_LDWT (one memory port, registered read) before ST_DONE
//   presents the result on out_o.
// Reset: V0..VF, I, timers and stack pointer clear, pc goes to 512.
//   Memory and return stack are not cleared.
// When the receiver stalls, the result holds on out_o and no new word is
//   taken until it is accepted.
// Depends on c8x_pkg, c8x_stream_if, c8x_ctrl, c8x_dpath, c8x_ram.
module chip8_instruction_executor_unit import c8x_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  c8x_stream_if.sink   in_i,
  c8x_stream_if.source out_o
);
  cmd_t cmd;
  sts_t sts;

  c8x_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  c8x_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .func_i(in_i.data.func), .opcode_i(in_i.data.opcode),
    .mem_address_i(in_i.data.mem_address), .mem_data_i(in_i.data.mem_data),
    .key_state_i(in_i.data.key_state), .random_byte_i(in_i.data.random_byte),
    .next_pc_o(out_o.data.next_pc), .read_data_o(out_o.data.read_data),
    .clear_screen_o(out_o.data.clear_screen),
    .unknown_opcode_o(out_o.data.unknown_opcode),
    .waiting_key_o(out_o.data.waiting_key),
    .sound_active_o(out_o.data.sound_active)
  );
endmodule

// ===== rtl/c8x_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module c8x_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/c8x_ctrl.sv =====
// Controller state machine of the CHIP-8 executor: sequences memory steps.
// Depends on c8x_pkg.
module c8x_ctrl import c8x_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.cnt   = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_d = '0;
        unique case (sts_i.func)
          FUNC_WRITE: begin
            cmd_o.mem_we = 1'b1;
            state_d = ST_DONE;
          end
          FUNC_READ: state_d = ST_RDWT;
          FUNC_TICK: begin
            cmd_o.exec = 1'b1;
            state_d = ST_DONE;
          end
          default: begin
            cmd_o.exec = 1'b1;
            if (sts_i.is_ret) state_d = ST_RET;
            else if (sts_i.is_bcd) state_d = ST_BCD;
            else if (sts_i.is_save) state_d = ST_SAVE;
            else if (sts_i.is_load) state_d = ST_LOAD;
            else state_d = ST_DONE;
          end
        endcase
      end
      ST_RDWT: begin
        cmd_o.rd_data = 1'b1;
        state_d = ST_DONE;
      end
      ST_RET: begin
        cmd_o.ret_pc = 1'b1;
        state_d = ST_DONE;
      end
      ST_BCD: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.mem_src = SRC_BCD;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) state_d = ST_DONE;
      end
      ST_SAVE: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.mem_src = SRC_REG;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == sts_i.x) state_d = ST_DONE;
      end
      ST_LOAD: state_d = ST_LDWT;  // address presented, data next cycle
      ST_LDWT: begin
        cmd_o.ld_reg = 1'b1;
        cnt_d = cnt_q + 4'd1;
        state_d = (cnt_q == sts_i.x) ? ST_DONE : ST_LOAD;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/c8x_dpath.sv =====
// Datapath of the CHIP-8 executor: architectural registers, stack and memory.
// Depends on c8x_pkg and c8x_ram.
module c8x_dpath import c8x_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] opcode_i,
  input  logic [11:0] mem_address_i,
  input  logic [7:0]  mem_data_i,
  input  logic [15:0] key_state_i,
  input  logic [7:0]  random_byte_i,
  output logic [11:0] next_pc_o,
  output logic [7:0]  read_data_o,
  output logic        clear_screen_o,
  output logic        unknown_opcode_o,
  output logic        waiting_key_o,
  output logic        sound_active_o
);
  logic [1:0]  func_q;
  logic [15:0] op_q, keys_q;
  logic [11:0] addr_q;
  logic [7:0]  data_q, rnd_q;
  logic [7:0]  v_q [16];
  logic [15:0] i_q;
  logic [11:0] pc_q;
  logic [SpW-1:0] sp_q;
  logic [7:0]  dt_q, st_q, rd_q;
  logic        clr_q, unk_q, wait_q;

  logic [3:0] x, y, n;
  logic [7:0] kk, a, b;
  logic [11:0] nnn, pc2;
  assign x = op_q[11:8];
  assign y = op_q[7:4];
  assign n = op_q[3:0];
  assign kk = op_q[7:0];
  assign nnn = op_q[11:0];
  assign a = v_q[x];
  assign b = v_q[y];
  assign pc2 = pc_q + 12'd2;

  logic is_f;
  assign is_f = (op_q[15:12] == 4'hF);
  assign sts_o.func    = func_q;
  assign sts_o.is_ret  = (op_q == 16'h00EE);
  assign sts_o.is_bcd  = is_f && (kk == 8'h33);
  assign sts_o.is_save = is_f && (kk == 8'h55);
  assign sts_o.is_load = is_f && (kk == 8'h65);
  assign sts_o.x       = x;

  // bcd digits
  logic [7:0] hund, tens, ones, rem1;
  always_comb begin
    hund = (a >= 8'd200) ? 8'd2 : (a >= 8'd100) ? 8'd1 : 8'd0;
    rem1 = a - hund * 8'd100;
    tens = 8'((16'(rem1) * 16'd205) >> 11);
    ones = rem1 - tens * 8'd10;
  end

  // memory port
  logic        mem_we;
  logic [11:0] mem_a;
  logic [7:0]  mem_wd, mem_rd;
  always_comb begin
    mem_we = cmd_i.mem_we;
    if (func_q != FUNC_EXEC) mem_a = addr_q;
    else mem_a = i_q[11:0] + 12'(cmd_i.cnt);
    unique case (cmd_i.mem_src)
      SRC_BCD: mem_wd = (cmd_i.cnt == 4'd0) ? hund : (cmd_i.cnt == 4'd1) ? tens : ones;
      SRC_REG: mem_wd = v_q[cmd_i.cnt];
      default: mem_wd = data_q;
    endcase
  end

  c8x_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i, .we_i(mem_we), .addr_i(mem_a), .wdata_i(mem_wd), .rdata_o(mem_rd)
  );

  // return stack: pop address presented during exec so data is ready in ST_RET
  logic           stk_we;
  logic [SpW-1:0] stk_a, sp_dec;
  logic [11:0]    stk_rd;
  assign sp_dec = sp_q - 1'b1;
  assign stk_we = cmd_i.exec && (func_q == FUNC_EXEC) && (op_q[15:12] == 4'h2);
  assign stk_a  = stk_we ? sp_q : sp_dec;

  c8x_ram #(.Width(12), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(stk_we), .addr_i(stk_a), .wdata_i(pc2), .rdata_o(stk_rd)
  );

  // lowest pressed key
  logic       key_hit;
  logic [3:0] key_idx;
  always_comb begin
    key_hit = 1'b0;
    key_idx = '0;
    for (int k = KeyCount - 1; k >= 0; k--) begin
      if (keys_q[k]) begin
        key_hit = 1'b1;
        key_idx = 4'(k);
      end
    end
  end

  logic kdown;
  assign kdown = (a < 8'(KeyCount)) && keys_q[a[3:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      op_q   <= opcode_i;
      addr_q <= mem_address_i;
      data_q <= mem_data_i;
      keys_q <= key_state_i;
      rnd_q  <= random_byte_i;
    end
  end

  logic [8:0] sum;
  assign sum = 9'(a) + 9'(b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 16; r++) v_q[r] <= '0;
      i_q <= '0;  pc_q <= 12'd512;  sp_q <= '0;
      dt_q <= '0; st_q <= '0;  rd_q <= '0;
      clr_q <= 1'b0; unk_q <= 1'b0; wait_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rd_q <= '0; clr_q <= 1'b0; unk_q <= 1'b0; wait_q <= 1'b0;
      end
      if (cmd_i.rd_data) rd_q <= mem_rd;
      if (cmd_i.ret_pc) pc_q <= stk_rd;
      if (cmd_i.ld_reg) v_q[cmd_i.cnt] <= mem_rd;
      if (cmd_i.exec && func_q == FUNC_TICK) begin
        if (dt_q != 0) dt_q <= dt_q - 8'd1;
        if (st_q != 0) st_q <= st_q - 8'd1;
      end
      if (cmd_i.exec && func_q == FUNC_EXEC) begin
        pc_q <= pc2;
        unique case (op_q[15:12])
          4'h0: begin
            if (y == 4'hE) begin
              if (n == 4'h0) clr_q <= 1'b1;
              else if (n == 4'hE) sp_q <= sp_dec;
            end else if (y != 4'h0) unk_q <= 1'b1;
          end
          4'h1: pc_q <= nnn;
          4'h2: begin
            sp_q <= sp_q + 1'b1;
            pc_q <= nnn;
          end
          4'h3: if (a == kk) pc_q <= pc_q + 12'd4;
          4'h4: if (a != kk) pc_q <= pc_q + 12'd4;
          4'h5: if (a == b) pc_q <= pc_q + 12'd4;
          4'h6: v_q[x] <= kk;
          4'h7: v_q[x] <= a + kk;
          4'h8: begin
            unique case (n)
              4'h0: v_q[x] <= b;
              4'h1: v_q[x] <= a | b;
              4'h2: v_q[x] <= a & b;
              4'h3: v_q[x] <= a ^ b;
              4'h4: begin v_q[15] <= {7'd0, sum[8]}; v_q[x] <= sum[7:0]; end
              4'h5: begin v_q[15] <= {7'd0, a > b}; v_q[x] <= a - b; end
              4'h6: begin v_q[15] <= {7'd0, a[0]}; v_q[x] <= a >> 1; end
              4'h7: begin v_q[15] <= {7'd0, b > a}; v_q[x] <= b - a; end
              4'hE: begin v_q[15] <= {7'd0, a[7]}; v_q[x] <= a << 1; end
              default: unk_q <= 1'b1;
            endcase
          end
          4'h9: if (a != b) pc_q <= pc_q + 12'd4;
          4'hA: i_q <= {4'd0, nnn};
          4'hB: pc_q <= 12'(v_q[0]) + nnn;
          4'hC: v_q[x] <= rnd_q & kk;
          4'hD: ;
          4'hE: begin
            if (kk == 8'h9E) begin
              if (kdown) pc_q <= pc_q + 12'd4;
            end else if (kk == 8'hA1) begin
              if (!kdown) pc_q <= pc_q + 12'd4;
            end else unk_q <= 1'b1;
          end
          default: begin
            unique case (kk)
              8'h07: v_q[x] <= dt_q;
              8'h0A: begin
                if (key_hit) v_q[x] <= {4'd0, key_idx};
                else begin
                  pc_q <= pc_q;
                  wait_q <= 1'b1;
                end
              end
              8'h15: dt_q <= a;
              8'h18: st_q <= a;
              8'h1E: i_q <= i_q + 16'(a);
              8'h29: i_q <= 16'(a) * 16'(FontHeight);
              8'h33, 8'h55, 8'h65: ;
              default: unk_q <= 1'b1;
            endcase
          end
        endcase
      end
    end
  end

  assign next_pc_o        = pc_q;
  assign read_data_o      = rd_q;
  assign clear_screen_o   = clr_q;
  assign unknown_opcode_o = unk_q;
  assign waiting_key_o    = wait_q;
  assign sound_active_o   = (st_q != 8'd0);
endmodule

// ===== dv/chip8_instruction_executor_unit_tb.sv =====
// Testbench for chip8_instruction_executor_unit: random and directed opcode,
// memory and tick words, checked against an in-bench CHIP-8 state predictor.
// Depends on c8x_pkg, c8x_stream_if and the RTL of the executor.
`timescale 1ns / 100ps

module chip8_instruction_executor_unit_tb;
  import c8x_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int LongHold      = 600;

  logic clk_i;
  logic rst_ni;

  c8x_stream_if #(.payload_t(in_word_t))  in_if ();
  c8x_stream_if #(.payload_t(out_word_t)) out_if ();

  chip8_instruction_executor_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicted CPU state
  logic [7:0]  v_reg [16];
  logic [15:0] i_reg;
  logic [11:0] pc;
  logic [11:0] call_stack [16];
  logic        call_ok [16];
  logic [3:0]  sp;
  logic [7:0]  dly_tmr;
  logic [7:0]  snd_tmr;
  logic [7:0]  ram [MemBytes];
  logic        ram_ok [MemBytes];
  logic [11:0] ram_written [$];

  in_word_t  pending_words [$];
  out_word_t expected_results [$];

  int errors = 0;
  int n_results = 0;
  int idle_cnt = 0;
  bit in_acc, out_acc;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit key_pressed(logic [15:0] keys, logic [7:0] k);
    if (k >= KeyCount) return 1'b0;
    return keys[k[3:0]];
  endfunction

  task automatic ram_store(logic [11:0] a, logic [7:0] d);
    ram[a] = d;
    if (!ram_ok[a]) ram_written.push_back(a);
    ram_ok[a] = 1'b1;
  endtask

  // advance the predicted state by one word and return its result
  task automatic cpu_step(input in_word_t w, output out_word_t r);
    logic [3:0]  x, y, n;
    logic [7:0]  kk, a, b;
    logic [11:0] nnn;
    logic [8:0]  sum;
    bit          found;
    r = '0;
    x = w.opcode[11:8];
    y = w.opcode[7:4];
    n = w.opcode[3:0];
    kk = w.opcode[7:0];
    nnn = w.opcode[11:0];
    a = v_reg[x];
    b = v_reg[y];
    case (w.func)
      FUNC_WRITE: ram_store(w.mem_address, w.mem_data);
      FUNC_READ:  r.read_data = ram[w.mem_address];
      FUNC_TICK: begin
        if (dly_tmr != 0) dly_tmr--;
        if (snd_tmr != 0) snd_tmr--;
      end
      default: begin
        pc = pc + 12'd2;
        case (w.opcode[15:12])
          4'h0: begin
            if (y == 4'hE) begin
              if (n == 4'h0) r.clear_screen = 1'b1;
              else if (n == 4'hE) begin
                sp = sp - 4'd1;
                pc = call_stack[sp];
              end
            end else r.unknown_opcode = (y != 4'h0);
          end
          4'h1: pc = nnn;
          4'h2: begin
            call_stack[sp] = pc;
            call_ok[sp] = 1'b1;
            sp = sp + 4'd1;
            pc = nnn;
          end
          4'h3: if (a == kk) pc = pc + 12'd2;
          4'h4: if (a != kk) pc = pc + 12'd2;
          4'h5: if (a == b) pc = pc + 12'd2;
          4'h6: v_reg[x] = kk;
          4'h7: v_reg[x] = a + kk;
          4'h8: begin
            case (n)
              4'h0: v_reg[x] = b;
              4'h1: v_reg[x] = a | b;
              4'h2: v_reg[x] = a & b;
              4'h3: v_reg[x] = a ^ b;
              4'h4: begin
                sum = a + b;
                v_reg[15] = {7'd0, sum[8]};
                v_reg[x] = sum[7:0];
              end
              4'h5: begin v_reg[15] = {7'd0, a > b}; v_reg[x] = a - b; end
              4'h6: begin v_reg[15] = {7'd0, a[0]}; v_reg[x] = a >> 1; end
              4'h7: begin v_reg[15] = {7'd0, b > a}; v_reg[x] = b - a; end
              4'hE: begin v_reg[15] = {7'd0, a[7]}; v_reg[x] = a << 1; end
              default: r.unknown_opcode = 1'b1;
            endcase
          end
          4'h9: if (a != b) pc = pc + 12'd2;
          4'hA: i_reg = {4'd0, nnn};
          4'hB: pc = {4'd0, v_reg[0]} + nnn;
          4'hC: v_reg[x] = w.random_byte & kk;
          4'hD: ;
          4'hE: begin
            if (kk == 8'h9E) begin
              if (key_pressed(w.key_state, a)) pc = pc + 12'd2;
            end else if (kk == 8'hA1) begin
              if (!key_pressed(w.key_state, a)) pc = pc + 12'd2;
            end else r.unknown_opcode = 1'b1;
          end
          default: begin
            case (kk)
              8'h07: v_reg[x] = dly_tmr;
              8'h0A: begin
                found = 1'b0;
                for (int k = 0; k < KeyCount; k++)
                  if (!found && w.key_state[k]) begin
                    v_reg[x] = k[7:0];
                    found = 1'b1;
                  end
                if (!found) begin
                  pc = pc - 12'd2;
                  r.waiting_key = 1'b1;
                end
              end
              8'h15: dly_tmr = a;
              8'h18: snd_tmr = a;
              8'h1E: i_reg = i_reg + {8'd0, a};
              8'h29: i_reg = a * FontHeight;
              8'h33: begin
                ram_store(i_reg[11:0], a / 100);
                ram_store(i_reg[11:0] + 12'd1, (a / 10) % 10);
                ram_store(i_reg[11:0] + 12'd2, a % 10);
              end
              8'h55: for (int k = 0; k <= x; k++) ram_store(i_reg[11:0] + k, v_reg[k]);
              8'h65: for (int k = 0; k <= x; k++) v_reg[k] = ram[12'(i_reg[11:0] + k)];
              default: r.unknown_opcode = 1'b1;
            endcase
          end
        endcase
      end
    endcase
    r.next_pc = pc;
    r.sound_active = (snd_tmr != 0);
  endtask

  // steer the word away from reads of bytes or stack entries never written
  task automatic queue_word(input in_word_t w);
    out_word_t r;
    bit clean;
    if (w.func == FUNC_READ && !ram_ok[w.mem_address]) begin
      if (ram_written.size() == 0) w.func = FUNC_WRITE;
      else w.mem_address = ram_written[$urandom_range(0, ram_written.size() - 1)];
    end
    if (w.func == FUNC_EXEC && w.opcode == 16'h00EE && !call_ok[sp - 4'd1])
      w.opcode = {4'h2, 12'($urandom)};
    if (w.func == FUNC_EXEC && w.opcode[15:12] == 4'hF && w.opcode[7:0] == 8'h65) begin
      clean = 1'b1;
      for (int k = 0; k <= w.opcode[11:8]; k++)
        if (!ram_ok[12'(i_reg[11:0] + k)]) clean = 1'b0;
      if (!clean) w.opcode[7:0] = 8'h55;
    end
    cpu_step(w, r);
    pending_words.push_back(w);
    expected_results.push_back(r);
  endtask

  task automatic add(func_e f, logic [15:0] op, logic [11:0] ad = '0, logic [7:0] d = '0,
                     logic [15:0] keys = '0, logic [7:0] rnd = '0);
    in_word_t w;
    w.func = f;
    w.opcode = op;
    w.mem_address = ad;
    w.mem_data = d;
    w.key_state = keys;
    w.random_byte = rnd;
    queue_word(w);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    logic [7:0] fx_codes [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
    op = 16'($urandom);
    case (op[15:12])
      4'h0: case ($urandom_range(0, 3))
              0: op = 16'h00E0;
              1: op = 16'h00EE;
              default: ;
            endcase
      4'h6: if ($urandom_range(0, 1)) op[7:4] = 4'h0;
      4'hE: if ($urandom_range(0, 4) != 0) op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
      4'hF: if ($urandom_range(0, 5) != 0) op[7:0] = fx_codes[$urandom_range(0, 8)];
      default: ;
    endcase
    return op;
  endfunction

  function automatic logic [15:0] random_keys();
    case ($urandom_range(0, 3))
      0: return 16'h0;
      1: return 16'h1 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // sender
  int send_gap = 0;
  always @(negedge clk_i) begin
    bit  v;
    if (rst_ni) begin
      v = in_if.valid;
      if (v && in_acc) begin
        v = 1'b0;
        send_gap = ((pending_words.size() / 60) % 3 == 0) ? 0 : $urandom_range(0, 17);
      end
      if (!v) begin
        if (send_gap > 0) send_gap--;
        else if (pending_words.size() > 0) begin
          in_if.data <= pending_words.pop_front();
          v = 1'b1;
        end
      end
      in_if.valid <= v;
    end
  end

  // receiver
  int recv_gap = 0;
  always @(negedge clk_i) begin
    bit r;
    if (rst_ni) begin
      r = out_if.ready;
      if (r && out_acc) begin
        if (n_results == 300) recv_gap = LongHold;
        else if ((n_results / 50) % 3 == 1) recv_gap = 0;
        else recv_gap = $urandom_range(0, 17);
        if (recv_gap > 0) r = 1'b0;
      end else if (!r) begin
        if (recv_gap > 1) recv_gap--;
        else begin
          recv_gap = 0;
          r = 1'b1;
        end
      end
      out_if.ready <= r;
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    out_word_t exp_r, got;
    in_acc = in_if.valid && in_if.ready;
    out_acc = out_if.valid && out_if.ready;
    if (out_acc) begin
      got = out_if.data;
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.next_pc !== exp_r.next_pc) begin
          $display("%0t: next_pc expected %h actual %h", $time, exp_r.next_pc, got.next_pc);
          errors++;
        end
        if (got.read_data !== exp_r.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, exp_r.read_data,
                   got.read_data);
          errors++;
        end
        if (got.clear_screen !== exp_r.clear_screen) begin
          $display("%0t: clear_screen expected %b actual %b", $time, exp_r.clear_screen,
                   got.clear_screen);
          errors++;
        end
        if (got.unknown_opcode !== exp_r.unknown_opcode) begin
          $display("%0t: unknown_opcode expected %b actual %b", $time, exp_r.unknown_opcode,
                   got.unknown_opcode);
          errors++;
        end
        if (got.waiting_key !== exp_r.waiting_key) begin
          $display("%0t: waiting_key expected %b actual %b", $time, exp_r.waiting_key,
                   got.waiting_key);
          errors++;
        end
        if (got.sound_active !== exp_r.sound_active) begin
          $display("%0t: sound_active expected %b actual %b", $time, exp_r.sound_active,
                   got.sound_active);
          errors++;
        end
      end
    end
    if (in_acc || out_acc || !rst_ni) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WatchdogLimit) begin
      $display("chip8_instruction_executor_unit_tb failed");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int f;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    for (int k = 0; k < 16; k++) begin
      v_reg[k] = '0;
      call_stack[k] = '0;
      call_ok[k] = 1'b0;
    end
    for (int k = 0; k < MemBytes; k++) begin
      ram[k] = '0;
      ram_ok[k] = 1'b0;
    end
    i_reg = '0;
    pc = 12'd512;
    sp = '0;
    dly_tmr = '0;
    snd_tmr = '0;

    // directed words
    add(FUNC_WRITE, 16'h0, 12'h000, 8'hFF);
    add(FUNC_WRITE, 16'h0, 12'hFFF, 8'h00);
    add(FUNC_READ,  16'h0, 12'h000);
    add(FUNC_READ,  16'h0, 12'hFFF);
    add(FUNC_EXEC,  16'h00E0);
    add(FUNC_EXEC,  16'h2FFE);
    add(FUNC_EXEC,  16'h00EE);
    add(FUNC_EXEC,  16'h0123);
    add(FUNC_EXEC,  16'h60FF);
    add(FUNC_EXEC,  16'h6F01);
    add(FUNC_EXEC,  16'h8F04);          // carry into VF, result wins
    add(FUNC_EXEC,  16'h800E);
    add(FUNC_EXEC,  16'h8008);
    add(FUNC_EXEC,  16'hF30A, 12'h0, 8'h0, 16'h0000);
    add(FUNC_EXEC,  16'hF30A, 12'h0, 8'h0, 16'h8000);
    add(FUNC_EXEC,  16'hE39E, 12'h0, 8'h0, 16'h8000);
    add(FUNC_EXEC,  16'hE0A1, 12'h0, 8'h0, 16'hFFFF);  // V0 >= 16: never pressed
    add(FUNC_EXEC,  16'hBFFF);
    add(FUNC_EXEC,  16'hAFFE);
    add(FUNC_EXEC,  16'hF033);          // address wraps past the top
    add(FUNC_EXEC,  16'hFF55);
    add(FUNC_EXEC,  16'hFF65);
    add(FUNC_EXEC,  16'hF018);
    add(FUNC_TICK,  16'h0);
    add(FUNC_EXEC,  16'hF0FF);

    @(negedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 800; i++) begin
      if (i == 400) begin
        // let the block drain fully before going on
        while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
      end
      w.opcode = random_opcode();
      w.mem_address = 12'($urandom);
      w.mem_data = 8'($urandom);
      w.key_state = random_keys();
      w.random_byte = 8'($urandom);
      f = $urandom_range(0, 19);
      w.func = f < 12 ? FUNC_EXEC : f < 15 ? FUNC_WRITE : f < 18 ? FUNC_READ : FUNC_TICK;
      queue_word(w);
    end

    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("chip8_instruction_executor_unit_tb passed");
    else $display("chip8_instruction_executor_unit_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/c8x_pkg.sv
rtl/c8x_stream_if.sv
rtl/c8x_ram.sv
rtl/c8x_ctrl.sv
rtl/c8x_dpath.sv
rtl/chip8_instruction_executor_unit.sv
dv/chip8_instruction_executor_unit_tb.sv
